// ===== hw/rtl/bfpt_pkg.sv =====
// ----------------------------------------------------------------------------
// Body frame pose tracker package
// Shared widths, register indexes, structs and CORDIC constants.
// ----------------------------------------------------------------------------
package bfpt_pkg;

    // Field widths of the item channels.
    localparam int POS_W     = 32;
    localparam int HEAD_W    = 15;
    localparam int TURN_W    = 18;
    localparam int CFG_W     = 16;
    localparam int CFG_IDX_W = 2;

    // Register indexes of the configuration port.
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_X       = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_Y       = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_HEADING = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ARRIVE_RAD   = 2'd3;

    // Register reset values.
    localparam logic [CFG_W-1:0] GAIN_X_RST       = 16'd1280;
    localparam logic [CFG_W-1:0] GAIN_Y_RST       = 16'd1280;
    localparam logic [CFG_W-1:0] GAIN_HEADING_RST = 16'd1024;
    localparam logic [CFG_W-1:0] ARRIVE_RAD_RST   = 16'd3277;

    // CORDIC chain length (valid range 8 to 24) and stage index width.
    localparam int CORDIC_STAGES = 14;
    localparam int STAGE_W       = $clog2(CORDIC_STAGES);
    localparam int ATAN_ENTRIES  = 24;
    localparam int ATAN_IDX_W    = 5;

    // Heading constants: Q4.12 and Q2.30.
    localparam logic signed [15:0] PI_Q12       = 16'sd12868;
    localparam logic signed [15:0] TWO_PI_Q12   = 16'sd25736;
    localparam logic signed [14:0] FOLD_LIM_Q12 = 15'sd6433;
    localparam logic signed [34:0] PI_Q30       = 35'sd3373259426;
    localparam logic signed [32:0] CORDIC_K_Q30 = 33'sd652032874;

    // Arctangent of 2^-i in Q2.30.
    localparam logic [29:0] ATAN_Q30 [ATAN_ENTRIES] = '{
        30'h3243F6A8, 30'h1DAC6705, 30'h0FADBAFC, 30'h07F56EA6, 30'h03FEAB76,
        30'h01FFD55B, 30'h00FFFAAA, 30'h007FFF55, 30'h003FFFEA, 30'h001FFFFD,
        30'h000FFFFF, 30'h0007FFFF, 30'h0003FFFF, 30'h0001FFFF, 30'h0000FFFF,
        30'h00007FFF, 30'h00003FFF, 30'h00001FFF, 30'h00000FFF, 30'h000007FF,
        30'h000003FF, 30'h000001FF, 30'h000000FF, 30'h0000007F
    };

    // Rotation state handed from cell to cell.
    typedef struct packed {
        logic signed [32:0] x;
        logic signed [32:0] y;
        logic signed [34:0] z;
    } t_cordic;

    // Item data that rides along the chain untouched.
    typedef struct packed {
        logic               neg;
        logic signed [32:0] dx;
        logic signed [32:0] dy;
        logic signed [15:0] dth;
        logic               near;
    } t_carry;

    // Configuration registers.
    typedef struct packed {
        logic [CFG_W-1:0] gain_x;
        logic [CFG_W-1:0] gain_y;
        logic [CFG_W-1:0] gain_heading;
        logic [CFG_W-1:0] arrive_radius;
    } t_cfg;

    // Arctangent of the given stage, zero extended to the z width.
    function automatic logic signed [34:0] atan_q30(input logic [STAGE_W-1:0] idx);
        logic [ATAN_IDX_W-1:0] w_idx;
        w_idx = ATAN_IDX_W'(idx);
        return $signed({5'b0, ATAN_Q30[w_idx]});
    endfunction

endpackage

// ===== hw/rtl/bfpt_in_if.sv =====
// ----------------------------------------------------------------------------
// Pose item channel
// Valid/ready channel carrying the current and target pose of one item.
// ----------------------------------------------------------------------------
interface bfpt_in_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [bfpt_pkg::POS_W-1:0]    pose_x;
    logic signed [bfpt_pkg::POS_W-1:0]    pose_y;
    logic signed [bfpt_pkg::HEAD_W-1:0]   pose_heading;
    logic signed [bfpt_pkg::POS_W-1:0]    target_x;
    logic signed [bfpt_pkg::POS_W-1:0]    target_y;
    logic signed [bfpt_pkg::HEAD_W-1:0]   target_heading;

    modport source (
        output valid, pose_x, pose_y, pose_heading, target_x, target_y, target_heading,
        input  ready
    );
    modport sink (
        input  valid, pose_x, pose_y, pose_heading, target_x, target_y, target_heading,
        output ready
    );
endinterface

// ===== hw/rtl/bfpt_out_if.sv =====
// ----------------------------------------------------------------------------
// Velocity command channel
// Valid/ready channel carrying the velocity command of one item.
// ----------------------------------------------------------------------------
interface bfpt_out_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [bfpt_pkg::POS_W-1:0]    vel_x;
    logic signed [bfpt_pkg::POS_W-1:0]    vel_y;
    logic signed [bfpt_pkg::TURN_W-1:0]   vel_turn;
    logic                                 arrived;

    modport source (
        output valid, vel_x, vel_y, vel_turn, arrived,
        input  ready
    );
    modport sink (
        input  valid, vel_x, vel_y, vel_turn, arrived,
        output ready
    );
endinterface

// ===== hw/rtl/bfpt_front.sv =====
// ----------------------------------------------------------------------------
// Pose tracker front stage
// Forms the pose errors, wraps the heading error and folds the heading
// into the CORDIC convergence range.
// ----------------------------------------------------------------------------
module bfpt_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_adv,
    bfpt_in_if.sink           i_pose,
    output logic              o_valid,
    output bfpt_pkg::t_cordic o_cordic,
    output bfpt_pkg::t_carry  o_carry
);
    import bfpt_pkg::*;

    logic               r_valid;
    t_cordic            r_cordic;
    t_carry             r_carry;
    t_cordic            n_cordic;
    t_carry             n_carry;
    logic signed [15:0] w_dth_raw;
    logic signed [34:0] w_zh;

    // The pipeline takes an item whenever it advances.
    assign i_pose.ready = i_adv;

    // Errors, heading wrap, near test and heading fold.
    always_comb begin
        n_carry.dx = $signed({i_pose.target_x[POS_W-1], i_pose.target_x})
                   - $signed({i_pose.pose_x[POS_W-1], i_pose.pose_x});
        n_carry.dy = $signed({i_pose.target_y[POS_W-1], i_pose.target_y})
                   - $signed({i_pose.pose_y[POS_W-1], i_pose.pose_y});
        w_dth_raw  = $signed({i_pose.target_heading[HEAD_W-1], i_pose.target_heading})
                   - $signed({i_pose.pose_heading[HEAD_W-1], i_pose.pose_heading});
        if (w_dth_raw > PI_Q12) begin
            n_carry.dth = w_dth_raw - TWO_PI_Q12;
        end else if (w_dth_raw < -PI_Q12) begin
            n_carry.dth = w_dth_raw + TWO_PI_Q12;
        end else begin
            n_carry.dth = w_dth_raw;
        end
        // A larger error can never fall inside a 16-bit radius.
        n_carry.near = (n_carry.dx > -33'sd65536) && (n_carry.dx < 33'sd65536)
                    && (n_carry.dy > -33'sd65536) && (n_carry.dy < 33'sd65536);

        // Heading to Q2.30; fold by pi when beyond half pi.
        w_zh = $signed({{2{i_pose.pose_heading[HEAD_W-1]}}, i_pose.pose_heading, 18'b0});
        n_cordic.x = CORDIC_K_Q30;
        n_cordic.y = '0;
        if (i_pose.pose_heading > FOLD_LIM_Q12) begin
            n_cordic.z  = w_zh - PI_Q30;
            n_carry.neg = 1'b1;
        end else if (i_pose.pose_heading < -FOLD_LIM_Q12) begin
            n_cordic.z  = w_zh + PI_Q30;
            n_carry.neg = 1'b1;
        end else begin
            n_cordic.z  = w_zh;
            n_carry.neg = 1'b0;
        end
    end

    // Valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_adv) begin
            r_valid <= i_pose.valid;
        end
    end

    // Item data.
    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_cordic <= n_cordic;
            r_carry  <= n_carry;
        end
    end

    assign o_valid  = r_valid;
    assign o_cordic = r_cordic;
    assign o_carry  = r_carry;

endmodule

// ===== hw/rtl/bfpt_cordic_cell.sv =====
// ----------------------------------------------------------------------------
// CORDIC rotation cell
// One rotation step of the sine/cosine chain; passes the item data along.
// ----------------------------------------------------------------------------
module bfpt_cordic_cell (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_adv,
    input  logic [bfpt_pkg::STAGE_W-1:0] i_stage,
    input  logic                         i_valid,
    input  bfpt_pkg::t_cordic            i_cordic,
    input  bfpt_pkg::t_carry             i_carry,
    output logic                         o_valid,
    output bfpt_pkg::t_cordic            o_cordic,
    output bfpt_pkg::t_carry             o_carry
);
    import bfpt_pkg::*;

    logic               r_valid;
    t_cordic            r_cordic;
    t_carry             r_carry;
    t_cordic            n_cordic;
    logic signed [32:0] w_xs;
    logic signed [32:0] w_ys;
    logic signed [34:0] w_atan;

    // The stage index is tied off, so the shifts reduce to wiring.
    assign w_xs   = i_cordic.x >>> i_stage;
    assign w_ys   = i_cordic.y >>> i_stage;
    assign w_atan = atan_q30(i_stage);

    // Rotate toward zero residual angle.
    always_comb begin
        if (!i_cordic.z[34]) begin
            n_cordic.x = i_cordic.x - w_ys;
            n_cordic.y = i_cordic.y + w_xs;
            n_cordic.z = i_cordic.z - w_atan;
        end else begin
            n_cordic.x = i_cordic.x + w_ys;
            n_cordic.y = i_cordic.y - w_xs;
            n_cordic.z = i_cordic.z + w_atan;
        end
    end

    // Valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_adv) begin
            r_valid <= i_valid;
        end
    end

    // Rotation state and item data.
    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_cordic <= n_cordic;
            r_carry  <= i_carry;
        end
    end

    assign o_valid  = r_valid;
    assign o_cordic = r_cordic;
    assign o_carry  = r_carry;

endmodule

// ===== hw/rtl/bfpt_back.sv =====
// ----------------------------------------------------------------------------
// Pose tracker back end
// Rounds sine and cosine, scales and rotates the errors, decides arrival
// and holds the command item until the sink takes it.
// ----------------------------------------------------------------------------
module bfpt_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  bfpt_pkg::t_cordic i_cordic,
    input  bfpt_pkg::t_carry  i_carry,
    input  bfpt_pkg::t_cfg    i_cfg,
    output logic              o_adv,
    bfpt_out_if.source        o_cmd
);
    import bfpt_pkg::*;

    // Clamp a rounded CORDIC result to [-1, 1] in Q1.14.
    function automatic logic signed [15:0] clamp_unit(input logic signed [17:0] v);
        if (v > 18'sd16384) begin
            return 16'sd16384;
        end else if (v < -18'sd16384) begin
            return -16'sd16384;
        end
        return v[15:0];
    endfunction

    // Saturate to a 32-bit velocity.
    function automatic logic signed [31:0] sat_vel(input logic signed [44:0] v);
        if (v > 45'sd2147483647) begin
            return 32'sh7FFFFFFF;
        end else if (v < -45'sd2147483648) begin
            return 32'sh80000000;
        end
        return v[31:0];
    endfunction

    // Saturate to an 18-bit turn rate.
    function automatic logic signed [17:0] sat_turn(input logic signed [25:0] v);
        if (v > 26'sd131071) begin
            return 18'sd131071;
        end else if (v < -26'sd131072) begin
            return -18'sd131072;
        end
        return v[17:0];
    endfunction

    // First stage: round trig values, gain products, squares.
    logic signed [33:0] w_xr;
    logic signed [33:0] w_yr;
    logic signed [15:0] w_c0;
    logic signed [15:0] w_s0;
    logic signed [16:0] w_dx17;
    logic signed [16:0] w_dy17;
    logic signed [33:0] w_sqx;
    logic signed [33:0] w_sqy;
    logic signed [49:0] w_ex;
    logic signed [49:0] w_ey;
    logic signed [32:0] w_vwp;

    logic               r_v1;
    logic signed [15:0] r_c;
    logic signed [15:0] r_s;
    logic signed [49:0] r_ex;
    logic signed [49:0] r_ey;
    logic [31:0]        r_sqx;
    logic [31:0]        r_sqy;
    logic signed [32:0] r_vwp;
    logic               r_near;
    logic [31:0]        r_rsq;

    // Second stage: rotation products, arrival test, turn rounding.
    logic [32:0]        w_d2;
    logic signed [33:0] w_vwr;
    logic signed [17:0] w_vw;

    logic               r_v2;
    logic signed [65:0] r_p_xc;
    logic signed [65:0] r_p_ys;
    logic signed [65:0] r_p_yc;
    logic signed [65:0] r_p_xs;
    logic signed [17:0] r_vw;
    logic               r_arr;

    // Output stage.
    logic signed [66:0] w_sx;
    logic signed [66:0] w_sy;
    logic               r_ov;
    logic signed [31:0] r_vel_x;
    logic signed [31:0] r_vel_y;
    logic signed [17:0] r_vel_turn;
    logic               r_arrived;

    // The whole pipeline moves unless a result is stuck at the output.
    assign o_adv = !r_ov || o_cmd.ready;

    always_comb begin
        w_xr   = $signed({i_cordic.x[32], i_cordic.x}) + 34'sd32768;
        w_yr   = $signed({i_cordic.y[32], i_cordic.y}) + 34'sd32768;
        w_c0   = clamp_unit(w_xr[33:16]);
        w_s0   = clamp_unit(w_yr[33:16]);
        w_dx17 = i_carry.dx[16:0];
        w_dy17 = i_carry.dy[16:0];
        w_sqx  = w_dx17 * w_dx17;
        w_sqy  = w_dy17 * w_dy17;
        w_ex   = i_carry.dx * $signed({1'b0, i_cfg.gain_x});
        w_ey   = i_carry.dy * $signed({1'b0, i_cfg.gain_y});
        w_vwp  = i_carry.dth * $signed({1'b0, i_cfg.gain_heading});
    end

    always_comb begin
        w_d2  = {1'b0, r_sqx} + {1'b0, r_sqy};
        w_vwr = $signed({r_vwp[32], r_vwp}) + 34'sd128;
        w_vw  = sat_turn(w_vwr[33:8]);
    end

    always_comb begin
        w_sx = $signed({r_p_xc[65], r_p_xc}) + $signed({r_p_ys[65], r_p_ys})
             + 67'sd2097152;
        w_sy = $signed({r_p_yc[65], r_p_yc}) - $signed({r_p_xs[65], r_p_xs})
             + 67'sd2097152;
    end

    // Valid flags of the three stages.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_ov <= 1'b0;
        end else if (o_adv) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_ov <= r_v2;
        end
    end

    // Squared radius follows the register; the user must change it only while idle, as the block does not enforce this.
    always_ff @(posedge i_clk) begin
        r_rsq <= i_cfg.arrive_radius * i_cfg.arrive_radius;
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        if (o_adv) begin
            r_c    <= i_carry.neg ? -w_c0 : w_c0;
            r_s    <= i_carry.neg ? -w_s0 : w_s0;
            r_ex   <= w_ex;
            r_ey   <= w_ey;
            r_sqx  <= w_sqx[31:0];
            r_sqy  <= w_sqy[31:0];
            r_vwp  <= w_vwp;
            r_near <= i_carry.near;

            r_p_xc <= r_ex * r_c;
            r_p_ys <= r_ey * r_s;
            r_p_yc <= r_ey * r_c;
            r_p_xs <= r_ex * r_s;
            r_vw   <= w_vw;
            r_arr  <= r_near && (w_d2 <= {1'b0, r_rsq});

            if (r_arr) begin
                r_vel_x    <= '0;
                r_vel_y    <= '0;
                r_vel_turn <= '0;
            end else begin
                r_vel_x    <= sat_vel(w_sx[66:22]);
                r_vel_y    <= sat_vel(w_sy[66:22]);
                r_vel_turn <= r_vw;
            end
            r_arrived <= r_arr;
        end
    end

    assign o_cmd.valid    = r_ov;
    assign o_cmd.vel_x    = r_vel_x;
    assign o_cmd.vel_y    = r_vel_y;
    assign o_cmd.vel_turn = r_vel_turn;
    assign o_cmd.arrived  = r_arrived;

endmodule

// ===== hw/rtl/body_frame_pose_tracker.sv =====
// ----------------------------------------------------------------------------
// Body frame pose tracker
// Proportional pose tracking controller for an omnidirectional base.
// ----------------------------------------------------------------------------
// Each pose item gives one command item. The block takes a new item every
// clock cycle while the command sink keeps up. An item passes through
// CORDIC_STAGES + 4 register stages: one stage forms the errors, one CORDIC
// cell per rotation step produces sine and cosine of the heading, and three
// stages scale, rotate, round and saturate. When the output register holds
// a command that the sink does not take, the whole pipeline holds and input
// ready drops. The user must write gains and the arrive radius through the
// configuration port only while no item is in flight; the block does not
// enforce this. Writes to other indexes are ignored.
module body_frame_pose_tracker (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [bfpt_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [bfpt_pkg::CFG_W-1:0]       i_cfg_data,
    bfpt_in_if.sink                          i_pose,
    bfpt_out_if.source                       o_cmd
);
    import bfpt_pkg::*;

    t_cfg    r_cfg;
    logic    w_adv;
    logic    w_valid  [CORDIC_STAGES+1];
    t_cordic w_cordic [CORDIC_STAGES+1];
    t_carry  w_carry  [CORDIC_STAGES+1];

    // Configuration register writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.gain_x        <= GAIN_X_RST;
            r_cfg.gain_y        <= GAIN_Y_RST;
            r_cfg.gain_heading  <= GAIN_HEADING_RST;
            r_cfg.arrive_radius <= ARRIVE_RAD_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_GAIN_X:       r_cfg.gain_x        <= i_cfg_data;
                REG_GAIN_Y:       r_cfg.gain_y        <= i_cfg_data;
                REG_GAIN_HEADING: r_cfg.gain_heading  <= i_cfg_data;
                REG_ARRIVE_RAD:   r_cfg.arrive_radius <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // Error forming stage.
    bfpt_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_adv    (w_adv),
        .i_pose   (i_pose),
        .o_valid  (w_valid[0]),
        .o_cordic (w_cordic[0]),
        .o_carry  (w_carry[0])
    );

    // Chain of CORDIC cells.
    for (genvar k = 0; k < CORDIC_STAGES; k++) begin : g_cell
        bfpt_cordic_cell u_cell (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_adv    (w_adv),
            .i_stage  (STAGE_W'(k)),
            .i_valid  (w_valid[k]),
            .i_cordic (w_cordic[k]),
            .i_carry  (w_carry[k]),
            .o_valid  (w_valid[k+1]),
            .o_cordic (w_cordic[k+1]),
            .o_carry  (w_carry[k+1])
        );
    end

    // Scaling, rotation and output register.
    bfpt_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (w_valid[CORDIC_STAGES]),
        .i_cordic (w_cordic[CORDIC_STAGES]),
        .i_carry  (w_carry[CORDIC_STAGES]),
        .i_cfg    (r_cfg),
        .o_adv    (w_adv),
        .o_cmd    (o_cmd)
    );

endmodule
